### rtl/assert_macros.svh
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every rising clock edge outside reset
`define DPALU_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("dpalu assertion failed");

// antecedent implies consequent in the same cycle
`define DPALU_ASSERT_IMPL(label, clk, rst, ante, cons) \
   `DPALU_ASSERT(label, clk, rst, (ante) |-> (cons))

`endif

### rtl/dpalu_pkg.sv
// package for the data-processing alu with shifter
// types, opcodes and shift kinds shared by the rtl modules
`default_nettype none

package dpalu_pkg;

   localparam int unsigned WORD_W = 32;

   typedef enum logic [3:0] {
      OP_AND = 4'b0000,
      OP_EOR = 4'b0001,
      OP_SUB = 4'b0010,
      OP_RSB = 4'b0011,
      OP_ADD = 4'b0100,
      OP_ADC = 4'b0101,
      OP_SBC = 4'b0110,
      OP_RSC = 4'b0111,
      OP_TST = 4'b1000,
      OP_TEQ = 4'b1001,
      OP_CMP = 4'b1010,
      OP_CMN = 4'b1011,
      OP_ORR = 4'b1100,
      OP_MOV = 4'b1101,
      OP_BIC = 4'b1110,
      OP_MVN = 4'b1111
   } opcode_type;

   typedef enum logic [1:0] {
      SHIFT_LSL = 2'd0,
      SHIFT_LSR = 2'd1,
      SHIFT_ASR = 2'd2,
      SHIFT_ROR = 2'd3
   } shift_kind_type;

   typedef struct packed {
      logic [WORD_W-1:0] instruction;
      logic [WORD_W-1:0] rn_value;
      logic [WORD_W-1:0] rm_value;
      logic [7:0]        rs_low_byte;
      logic              carry_in;
      logic              overflow_in;
   } req_type;

   typedef struct packed {
      logic [WORD_W-1:0] result;
      logic              writes_result;
      logic [3:0]        dest_index;
      logic              set_flags;
      logic              flag_n;
      logic              flag_z;
      logic              flag_c;
      logic              flag_v;
   } rsp_type;

   typedef struct packed {
      logic [WORD_W-1:0] operand;
      logic              carry;
   } shift_out_type;

endpackage

`default_nettype wire

### rtl/dpalu_shifter.sv
// barrel shifter: forms the shifter operand and shifter carry
// depends on dpalu_pkg
`default_nettype none

module dpalu_shifter
   import dpalu_pkg::*;
(
   input  wire req_type       req,
   output shift_out_type      shift_out
);

   logic [WORD_W-1:0]   ins;
   logic [WORD_W-1:0]   rm;
   logic [7:0]          rs;
   logic                cin;
   shift_kind_type      kind;
   logic                reg_form;
   logic [4:0]          imm_s;
   logic [5:0]          amt;
   logic [4:0]          rot5;
   logic [WORD_W:0]     lsl_wide;
   logic [WORD_W:0]     lsr_wide;
   logic [WORD_W:0]     asr_wide;
   logic [2*WORD_W-1:0] ror_wide;
   logic [2*WORD_W-1:0] imm_wide;
   logic [WORD_W-1:0]   imm_val;

   assign ins      = req.instruction;
   assign rm       = req.rm_value;
   assign rs       = req.rs_low_byte;
   assign cin      = req.carry_in;
   assign kind     = shift_kind_type'(ins[6:5]);
   assign reg_form = ins[4];
   assign imm_s    = ins[11:7];

   always_comb begin
      if (!reg_form) begin
         amt  = {1'b0, imm_s};
         rot5 = imm_s;
         if ((imm_s == 5'd0) && ((kind == SHIFT_LSR) || (kind == SHIFT_ASR))) begin
            amt = 6'd32;
         end
      end else begin
         amt  = (rs >= 8'd32) ? 6'd32 : rs[5:0];
         rot5 = rs[4:0];
      end
   end

   assign lsl_wide = {1'b0, rm} << amt;
   assign lsr_wide = {rm, 1'b0} >> amt;
   assign asr_wide = $unsigned($signed({rm, 1'b0}) >>> amt);
   assign ror_wide = {rm, rm} >> rot5;
   assign imm_wide = {24'd0, ins[7:0], 24'd0, ins[7:0]} >> {ins[11:8], 1'b0};
   assign imm_val  = imm_wide[WORD_W-1:0];

   always_comb begin
      shift_out.operand = rm;
      shift_out.carry   = cin;
      if (ins[25]) begin
         shift_out.operand = imm_val;
         shift_out.carry   = (ins[11:8] == 4'd0) ? cin : imm_val[WORD_W-1];
      end else if (reg_form && (rs == 8'd0)) begin
         shift_out.operand = rm;
         shift_out.carry   = cin;
      end else begin
         case (kind)
            SHIFT_LSL: begin
               if (!reg_form && (imm_s == 5'd0)) begin
                  shift_out.operand = rm;
                  shift_out.carry   = cin;
               end else if (reg_form && (rs > 8'd32)) begin
                  shift_out.operand = '0;
                  shift_out.carry   = 1'b0;
               end else begin
                  shift_out.operand = lsl_wide[WORD_W-1:0];
                  shift_out.carry   = lsl_wide[WORD_W];
               end
            end
            SHIFT_LSR: begin
               if (reg_form && (rs > 8'd32)) begin
                  shift_out.operand = '0;
                  shift_out.carry   = 1'b0;
               end else begin
                  shift_out.operand = lsr_wide[WORD_W:1];
                  shift_out.carry   = lsr_wide[0];
               end
            end
            SHIFT_ASR: begin
               shift_out.operand = asr_wide[WORD_W:1];
               shift_out.carry   = asr_wide[0];
            end
            SHIFT_ROR: begin
               if (!reg_form && (imm_s == 5'd0)) begin
                  // rrx
                  shift_out.operand = {cin, rm[WORD_W-1:1]};
                  shift_out.carry   = rm[0];
               end else if (rot5 == 5'd0) begin
                  shift_out.operand = rm;
                  shift_out.carry   = rm[WORD_W-1];
               end else begin
                  shift_out.operand = ror_wide[WORD_W-1:0];
                  shift_out.carry   = ror_wide[WORD_W-1];
               end
            end
            default: begin
               shift_out.operand = rm;
               shift_out.carry   = cin;
            end
         endcase
      end
   end

endmodule

`default_nettype wire

### rtl/dpalu_alu.sv
// alu: applies the opcode to rn and the shifter operand, forms the flags
// depends on dpalu_pkg
`default_nettype none

module dpalu_alu
   import dpalu_pkg::*;
(
   input  wire req_type       req,
   input  wire shift_out_type shift_out,
   output rsp_type            rsp
);

   opcode_type        opc;
   logic [WORD_W-1:0] rn;
   logic [WORD_W-1:0] op;
   logic [WORD_W-1:0] add_a;
   logic [WORD_W-1:0] add_b;
   logic              add_c;
   logic [WORD_W:0]   sum;
   logic [WORD_W-1:0] res;
   logic              arith;
   logic              add_v;

   assign opc = opcode_type'(req.instruction[24:21]);
   assign rn  = req.rn_value;
   assign op  = shift_out.operand;

   always_comb begin
      add_a = rn;
      add_b = op;
      add_c = 1'b0;
      arith = 1'b1;
      case (opc)
         OP_SUB, OP_CMP: begin
            add_b = ~op;
            add_c = 1'b1;
         end
         OP_RSB: begin
            add_a = op;
            add_b = ~rn;
            add_c = 1'b1;
         end
         OP_ADD, OP_CMN: begin
            add_c = 1'b0;
         end
         OP_ADC: begin
            add_c = req.carry_in;
         end
         OP_SBC: begin
            add_b = ~op;
            add_c = req.carry_in;
         end
         OP_RSC: begin
            add_a = op;
            add_b = ~rn;
            add_c = req.carry_in;
         end
         default: begin
            arith = 1'b0;
         end
      endcase
   end

   assign sum   = {1'b0, add_a} + {1'b0, add_b} + {{WORD_W{1'b0}}, add_c};
   assign add_v = (add_a[WORD_W-1] ^ sum[WORD_W-1]) & (add_b[WORD_W-1] ^ sum[WORD_W-1]);

   always_comb begin
      case (opc)
         OP_AND, OP_TST: res = rn & op;
         OP_EOR, OP_TEQ: res = rn ^ op;
         OP_ORR:         res = rn | op;
         OP_MOV:         res = op;
         OP_BIC:         res = rn & ~op;
         OP_MVN:         res = ~op;
         default:        res = sum[WORD_W-1:0];
      endcase
   end

   always_comb begin
      rsp.result        = res;
      rsp.writes_result = !((opc == OP_TST) || (opc == OP_TEQ) ||
                            (opc == OP_CMP) || (opc == OP_CMN));
      rsp.dest_index    = req.instruction[15:12];
      rsp.set_flags     = req.instruction[20];
      rsp.flag_n        = res[WORD_W-1];
      rsp.flag_z        = (res == '0);
      rsp.flag_c        = arith ? sum[WORD_W] : shift_out.carry;
      rsp.flag_v        = arith ? add_v : req.overflow_in;
   end

endmodule

`default_nettype wire

### rtl/data_processing_alu_with_shifter_top.sv
// top level of the data-processing alu with barrel shifter
// depends on dpalu_pkg, dpalu_shifter and dpalu_alu
//
// An instruction is taken when start is high and busy is low; busy is never
// raised, so one instruction can be taken every cycle. The instruction is
// registered, passes the shifter and the alu in the next cycle, and its result
// is registered in rsp_ff: rsp_strobe marks the result for one cycle as it leaves
// rsp_ff, and results leave in the order instructions came in. The
// receiver cannot stall, so it must take each result in the cycle it shows.
`default_nettype none

module data_processing_alu_with_shifter_top
   import dpalu_pkg::*;
(
   input  wire     clock,
   input  wire     reset,
   input  wire     start,
   output logic    busy,
   input  wire     req_type req_data,
   output logic    rsp_strobe,
   output rsp_type rsp_data
);

   req_type       req_ff;
   logic          req_valid_ff;
   logic          req_valid_in;
   rsp_type       rsp_ff;
   rsp_type       rsp_in;
   logic          rsp_valid_ff;
   shift_out_type shift_out;

   assign busy         = 1'b0;
   assign req_valid_in = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= req_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid_in) begin
         req_ff <= req_data;
      end
      if (req_valid_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   dpalu_shifter u_shifter (
      .req       (req_ff),
      .shift_out (shift_out)
   );

   dpalu_alu u_alu (
      .req       (req_ff),
      .shift_out (shift_out),
      .rsp       (rsp_in)
   );

   assign rsp_strobe = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

endmodule

`default_nettype wire

### rtl/dpalu_checker.sv
// port-level checker for the data-processing alu, bound to the top level
// depends on dpalu_pkg and assert_macros.svh
`default_nettype none

`include "assert_macros.svh"

module dpalu_checker
   import dpalu_pkg::*;
(
   input wire     clock,
   input wire     reset,
   input wire     start,
   input wire     busy,
   input wire     req_type req_data,
   input wire     rsp_strobe,
   input wire     rsp_type rsp_data
);

   `DPALU_ASSERT_IMPL(a_xfer_gives_rsp, clock, reset, start && !busy, ##2 rsp_strobe)
   `DPALU_ASSERT_IMPL(a_rsp_has_xfer, clock, reset, rsp_strobe, $past(start && !busy && !reset, 2))
   `DPALU_ASSERT_IMPL(a_zero_flag, clock, reset, rsp_strobe, rsp_data.flag_z == (rsp_data.result == '0))
   `DPALU_ASSERT_IMPL(a_dest_index, clock, reset, rsp_strobe, rsp_data.dest_index == $past(req_data.instruction[15:12], 2))
   `DPALU_ASSERT_IMPL(a_write_enable, clock, reset, rsp_strobe, rsp_data.writes_result == ($past(req_data.instruction[24:23], 2) != 2'b10))

endmodule

bind data_processing_alu_with_shifter_top dpalu_checker u_dpalu_checker (.*);

`default_nettype wire

### tb/data_processing_alu_with_shifter_top_tb.sv
// self-checking testbench for the data-processing alu with barrel shifter
// depends on dpalu_pkg and data_processing_alu_with_shifter_top; predicts each
// transfer in a scoreboard class and checks every strobed result in order
`default_nettype none

module data_processing_alu_with_shifter_top_tb;
   import dpalu_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned RANDOM_ITEMS = 1900;
   localparam int unsigned CYCLE_LIMIT  = 400000;
   localparam int unsigned DRAIN_CYCLES = 6;

   class alu_result_checker;
      rsp_type expected_results[$];
      int      mismatch_count = 0;

      function logic [31:0] rotate_right(logic [31:0] x, int n);
         n = n % 32;
         return (n == 0) ? x : ((x >> n) | (x << (32 - n)));
      endfunction

      function void predict_operand2(req_type r, output logic [31:0] opnd,
                                     output logic sc);
         logic [31:0]    ins;
         logic [31:0]    rm;
         logic           sign;
         logic           cin;
         shift_kind_type kind;
         int             n;
         ins  = r.instruction;
         rm   = r.rm_value;
         sign = rm[31];
         cin  = r.carry_in;
         kind = shift_kind_type'(ins[6:5]);
         if (ins[25]) begin
            n    = 2 * int'(ins[11:8]);
            opnd = rotate_right({24'd0, ins[7:0]}, n);
            sc   = (n == 0) ? cin : opnd[31];
         end else if (!ins[4]) begin
            n = int'(ins[11:7]);
            case (kind)
               SHIFT_LSL: begin
                  if (n == 0) begin
                     opnd = rm;
                     sc   = cin;
                  end else begin
                     opnd = rm << n;
                     sc   = rm[32 - n];
                  end
               end
               SHIFT_LSR: begin
                  if (n == 0) begin
                     opnd = '0;
                     sc   = sign;
                  end else begin
                     opnd = rm >> n;
                     sc   = rm[n - 1];
                  end
               end
               SHIFT_ASR: begin
                  if (n == 0) begin
                     opnd = {32{sign}};
                     sc   = sign;
                  end else begin
                     opnd = $signed(rm) >>> n;
                     sc   = rm[n - 1];
                  end
               end
               default: begin
                  if (n == 0) begin
                     opnd = {cin, rm[31:1]};
                     sc   = rm[0];
                  end else begin
                     opnd = rotate_right(rm, n);
                     sc   = rm[n - 1];
                  end
               end
            endcase
         end else begin
            n = int'(r.rs_low_byte);
            if (n == 0) begin
               opnd = rm;
               sc   = cin;
            end else begin
               case (kind)
                  SHIFT_LSL: begin
                     if (n < 32) begin
                        opnd = rm << n;
                        sc   = rm[32 - n];
                     end else begin
                        opnd = '0;
                        sc   = (n == 32) ? rm[0] : 1'b0;
                     end
                  end
                  SHIFT_LSR: begin
                     if (n < 32) begin
                        opnd = rm >> n;
                        sc   = rm[n - 1];
                     end else begin
                        opnd = '0;
                        sc   = (n == 32) ? sign : 1'b0;
                     end
                  end
                  SHIFT_ASR: begin
                     if (n < 32) begin
                        opnd = $signed(rm) >>> n;
                        sc   = rm[n - 1];
                     end else begin
                        opnd = {32{sign}};
                        sc   = sign;
                     end
                  end
                  default: begin
                     n = n % 32;
                     if (n == 0) begin
                        opnd = rm;
                        sc   = sign;
                     end else begin
                        opnd = rotate_right(rm, n);
                        sc   = rm[n - 1];
                     end
                  end
               endcase
            end
         end
      endfunction

      function void add_with_carry(logic [31:0] a, logic [31:0] b, logic cin,
                                   output logic [31:0] sum, output logic c,
                                   output logic v);
         logic [32:0] wide;
         wide = {1'b0, a} + {1'b0, b} + {32'd0, cin};
         sum  = wide[31:0];
         c    = wide[32];
         v    = (a[31] ^ sum[31]) & (b[31] ^ sum[31]);
      endfunction

      function rsp_type execute_instruction(req_type r);
         rsp_type     want;
         opcode_type  opc;
         logic [31:0] opnd;
         logic [31:0] rn;
         logic [31:0] res;
         logic        sc;
         logic        fc;
         logic        fv;
         opc = opcode_type'(r.instruction[24:21]);
         rn  = r.rn_value;
         predict_operand2(r, opnd, sc);
         fc = sc;
         fv = r.overflow_in;
         case (opc)
            OP_AND, OP_TST: res = rn & opnd;
            OP_EOR, OP_TEQ: res = rn ^ opnd;
            OP_SUB, OP_CMP: add_with_carry(rn, ~opnd, 1'b1, res, fc, fv);
            OP_RSB:         add_with_carry(opnd, ~rn, 1'b1, res, fc, fv);
            OP_ADD, OP_CMN: add_with_carry(rn, opnd, 1'b0, res, fc, fv);
            OP_ADC:         add_with_carry(rn, opnd, r.carry_in, res, fc, fv);
            OP_SBC:         add_with_carry(rn, ~opnd, r.carry_in, res, fc, fv);
            OP_RSC:         add_with_carry(opnd, ~rn, r.carry_in, res, fc, fv);
            OP_ORR:         res = rn | opnd;
            OP_MOV:         res = opnd;
            OP_BIC:         res = rn & ~opnd;
            default:        res = ~opnd;
         endcase
         case (opc)
            OP_TST, OP_TEQ, OP_CMP, OP_CMN: want.writes_result = 1'b0;
            default:                        want.writes_result = 1'b1;
         endcase
         want.result     = res;
         want.dest_index = r.instruction[15:12];
         want.set_flags  = r.instruction[20];
         want.flag_n     = res[31];
         want.flag_z     = (res == '0);
         want.flag_c     = fc;
         want.flag_v     = fv;
         return want;
      endfunction

      function void note_instruction(req_type r);
         expected_results.push_back(execute_instruction(r));
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            $error("%s expected %h got %h", name, want, got);
            mismatch_count++;
         end
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         if (expected_results.size() == 0) begin
            $error("result %h with no instruction pending", got);
            mismatch_count++;
            return;
         end
         want = expected_results.pop_front();
         compare_field("result", want.result, got.result);
         compare_field("writes_result", 32'(want.writes_result), 32'(got.writes_result));
         compare_field("dest_index", 32'(want.dest_index), 32'(got.dest_index));
         compare_field("set_flags", 32'(want.set_flags), 32'(got.set_flags));
         compare_field("flag_n", 32'(want.flag_n), 32'(got.flag_n));
         compare_field("flag_z", 32'(want.flag_z), 32'(got.flag_z));
         compare_field("flag_c", 32'(want.flag_c), 32'(got.flag_c));
         compare_field("flag_v", 32'(want.flag_v), 32'(got.flag_v));
      endfunction
   endclass

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_strobe;
   rsp_type rsp_data;
   int unsigned cycle_count;

   alu_result_checker checker_h;

   data_processing_alu_with_shifter_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // record each transfer and check each strobed result
   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy)
            checker_h.note_instruction(req_data);
         if (rsp_strobe)
            checker_h.check_result(rsp_data);
      end
   end

   function automatic logic [31:0] dp_word(opcode_type op, bit s, bit imm,
                                           logic [3:0] rd, logic [11:0] operand2);
      return {4'hE, 2'b00, imm, op, s, 4'h0, rd, operand2};
   endfunction

   function automatic logic [11:0] shift_by_imm(logic [4:0] amt, shift_kind_type kind);
      return {amt, kind, 1'b0, 4'h0};
   endfunction

   function automatic logic [11:0] shift_by_reg(shift_kind_type kind, bit bit7);
      return {4'h0, bit7, kind, 1'b1, 4'h0};
   endfunction

   function automatic logic [31:0] random_word();
      case ($urandom_range(0, 7))
         0:       return 32'h0000_0000;
         1:       return 32'hFFFF_FFFF;
         2:       return 32'h8000_0000;
         3:       return 32'h7FFF_FFFF;
         4:       return 32'h1 << $urandom_range(0, 31);
         default: return $urandom;
      endcase
   endfunction

   function automatic req_type random_item();
      req_type     r;
      logic [7:0]  amounts[9];
      amounts = '{8'd0, 8'd1, 8'd31, 8'd32, 8'd33, 8'd63, 8'd64, 8'd65, 8'd255};
      r.instruction = $urandom;
      r.rn_value    = random_word();
      r.rm_value    = random_word();
      if ($urandom_range(0, 2) == 0)
         r.rs_low_byte = amounts[$urandom_range(0, 8)];
      else
         r.rs_low_byte = 8'($urandom_range(0, 255));
      r.carry_in    = 1'($urandom_range(0, 1));
      r.overflow_in = 1'($urandom_range(0, 1));
      return r;
   endfunction

   task automatic send_item(req_type item);
      @(negedge clock);
      start    <= 1'b1;
      req_data <= item;
      do
         @(posedge clock);
      while (busy);
   endtask

   task automatic send_fields(logic [31:0] ins, logic [31:0] rn, logic [31:0] rm,
                              logic [7:0] rs, logic cin, logic vin);
      req_type r;
      r.instruction = ins;
      r.rn_value    = rn;
      r.rm_value    = rm;
      r.rs_low_byte = rs;
      r.carry_in    = cin;
      r.overflow_in = vin;
      send_item(r);
   endtask

   task automatic pause_sender(int unsigned cycles);
      @(negedge clock);
      start <= 1'b0;
      repeat (cycles) @(negedge clock);
   endtask

   task automatic run_directed();
      send_fields('0, '0, '0, '0, 1'b0, 1'b0);
      send_fields('1, '1, '1, '1, 1'b1, 1'b1);
      // unrotated and rotated immediates
      send_fields(dp_word(OP_AND, 1, 1, 4'd1, 12'h0FF), '1, '0, 8'd0, 1'b1, 1'b0);
      send_fields(dp_word(OP_EOR, 1, 1, 4'd2, 12'h103), '0, '0, 8'd0, 1'b0, 1'b1);
      send_fields(dp_word(OP_MOV, 1, 1, 4'd3, 12'hFFF), '0, '0, 8'd0, 1'b0, 1'b0);
      // immediate shifts, zero amounts and an amount of 31
      send_fields(dp_word(OP_SUB, 1, 0, 4'd4, shift_by_imm(5'd0, SHIFT_LSL)),
                  32'h0, '1, 8'd0, 1'b1, 1'b0);
      send_fields(dp_word(OP_RSB, 1, 0, 4'd5, shift_by_imm(5'd0, SHIFT_LSR)),
                  32'h1, 32'h8000_0000, 8'd0, 1'b0, 1'b0);
      send_fields(dp_word(OP_ADD, 1, 0, 4'd6, shift_by_imm(5'd0, SHIFT_ASR)),
                  32'h7FFF_FFFF, 32'h8000_0000, 8'd0, 1'b0, 1'b0);
      send_fields(dp_word(OP_ADC, 1, 0, 4'd7, shift_by_imm(5'd0, SHIFT_ROR)),
                  32'h0, 32'h1, 8'd0, 1'b1, 1'b0);
      send_fields(dp_word(OP_MVN, 1, 0, 4'd8, shift_by_imm(5'd31, SHIFT_LSL)),
                  32'h0, 32'h1, 8'd0, 1'b0, 1'b1);
      // register shifts: zero, 32, above 32
      send_fields(dp_word(OP_SBC, 1, 0, 4'd9, shift_by_reg(SHIFT_LSL, 0)),
                  32'h0, 32'h1, 8'd0, 1'b0, 1'b0);
      send_fields(dp_word(OP_RSC, 1, 0, 4'd10, shift_by_reg(SHIFT_LSL, 0)),
                  32'h5, 32'h1, 8'd32, 1'b1, 1'b0);
      // compare opcode without the S bit
      send_fields(dp_word(OP_TST, 0, 0, 4'd11, shift_by_reg(SHIFT_LSL, 0)),
                  '1, '1, 8'd33, 1'b1, 1'b1);
      send_fields(dp_word(OP_TEQ, 1, 0, 4'd12, shift_by_reg(SHIFT_LSR, 0)),
                  32'h8000_0000, 32'h8000_0000, 8'd32, 1'b0, 1'b0);
      send_fields(dp_word(OP_CMP, 1, 0, 4'd13, shift_by_reg(SHIFT_LSR, 0)),
                  32'h0, '1, 8'd200, 1'b1, 1'b0);
      send_fields(dp_word(OP_CMN, 1, 0, 4'd14, shift_by_reg(SHIFT_ASR, 0)),
                  32'h1, 32'h8000_0000, 8'd255, 1'b0, 1'b0);
      send_fields(dp_word(OP_ORR, 1, 0, 4'd0, shift_by_reg(SHIFT_ROR, 0)),
                  32'h0, 32'h8000_0001, 8'd32, 1'b0, 1'b0);
      // bit 7 set in register form, destination 15 with S
      send_fields(dp_word(OP_MOV, 1, 0, 4'd15, shift_by_reg(SHIFT_ROR, 1)),
                  32'h0, 32'h8000_0001, 8'd64, 1'b0, 1'b1);
      send_fields(dp_word(OP_BIC, 1, 0, 4'd1, shift_by_reg(SHIFT_ROR, 0)),
                  '1, 32'h0000_0003, 8'd33, 1'b0, 1'b0);
      send_fields(dp_word(OP_MOV, 0, 0, 4'd2, shift_by_reg(SHIFT_ASR, 0)),
                  32'h0, 32'h8000_0000, 8'd31, 1'b0, 1'b0);
      // adder overflow and subtraction carry
      send_fields(dp_word(OP_ADD, 1, 1, 4'd3, 12'h001), 32'h7FFF_FFFF, '0, 8'd0, 1'b0, 1'b0);
      send_fields(dp_word(OP_SUB, 1, 1, 4'd4, 12'h001), 32'h8000_0000, '0, 8'd0, 1'b0, 1'b0);
      send_fields(dp_word(OP_SUB, 1, 1, 4'd5, 12'h000), 32'h0, '0, 8'd0, 1'b0, 1'b1);
   endtask

   task automatic run_random();
      int unsigned sent;
      int unsigned burst;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         burst = $urandom_range(1, 24);
         repeat (burst) begin
            send_item(random_item());
            sent++;
         end
         if ($urandom_range(0, 3) != 0)
            pause_sender($urandom_range(0, 8));
      end
   endtask

   initial begin
      clock       = 1'b0;
      reset       = 1'b1;
      start       = 1'b0;
      req_data    = '0;
      cycle_count = 0;
      checker_h   = new();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      run_directed();
      pause_sender(3);
      run_random();
      @(negedge clock);
      start <= 1'b0;
      while (checker_h.expected_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (checker_h.mismatch_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

`default_nettype wire

### files.f
+incdir+rtl
rtl/dpalu_pkg.sv
rtl/dpalu_shifter.sv
rtl/dpalu_alu.sv
rtl/data_processing_alu_with_shifter_top.sv
rtl/dpalu_checker.sv
tb/data_processing_alu_with_shifter_top_tb.sv
